[sv/slisd_pkg.sv]
`default_nettype none

package slisd_pkg;

  // Number of cells in the chain.
  localparam int CAPACITY = 16;

  // Width of the internal occupancy counter, able to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Fixed field widths on the ports.
  localparam int VAL_W       = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int OUT_CNT_W   = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * OUT_CNT_W;

  // The match vector is counted eight bits a cycle.
  localparam int GRP_BITS = 8;
  localparam int NGRP     = (CAPACITY + GRP_BITS - 1) / GRP_BITS;
  localparam int EQ_W     = NGRP * GRP_BITS;
  localparam int GRP_W    = $clog2(NGRP + 1);
  localparam int POP_W    = $clog2(GRP_BITS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_COUNT = 2'd2,
    S_DONE  = 2'd3
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                    ins_en;
    logic                    del_en;
    logic signed [VAL_W-1:0] key;
  } cell_cmd_t;

endpackage

`default_nettype wire

[sv/slisd_cell.sv]
`default_nettype none

module slisd_cell (
  input  wire logic                               clk,
  input  wire slisd_pkg::cell_cmd_t               cmd,
  input  wire logic                               occ,
  input  wire logic                               left_lt,
  input  wire logic                               left_occ,
  input  wire logic signed [slisd_pkg::VAL_W-1:0] left_val,
  input  wire logic signed [slisd_pkg::VAL_W-1:0] right_val,
  input  wire logic                               hit_in,
  output logic signed [slisd_pkg::VAL_W-1:0]      val,
  output logic                                    lt,
  output logic                                    eq,
  output logic                                    hit_out
);

  logic signed [slisd_pkg::VAL_W-1:0] val_r;
  logic signed [slisd_pkg::VAL_W-1:0] val_nxt;
  logic                               take_new;
  logic                               shift_up;
  logic                               shift_down;

  // Compare the held entry against the broadcast key.
  always_comb begin
    lt      = occ && (val_r < cmd.key);
    eq      = occ && (val_r == cmd.key);
    hit_out = hit_in | eq;
    val     = val_r;
  end

  // An insert lands in the first cell not below the key; cells above it
  // take their left neighbor. A delete pulls the right neighbor into every
  // cell at or above the first match.
  always_comb begin
    take_new   = cmd.ins_en && !lt && left_lt;
    shift_up   = cmd.ins_en && !left_lt && left_occ;
    shift_down = cmd.del_en && hit_out;
    val_nxt    = val_r;
    if (take_new) begin
      val_nxt = cmd.key;
    end else if (shift_up) begin
      val_nxt = left_val;
    end else if (shift_down) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

[sv/sorted_list_insert_search_delete.sv]
`default_nettype none

// Sorted list of up to CAPACITY signed 32-bit values held in a chain of
// cells, ascending from cell 0. An input beat carries the operation in
// in_tuser and the value or key in in_tdata: insert, count the entries equal
// to the key, or delete one such entry. Each beat gives exactly one result
// beat with the status in out_tuser and the match count and occupancy after
// the operation in out_tdata. One item is handled at a time: after the
// accepting edge comes an execute state in which every cell compares and
// shifts in parallel, then a count state in which the match vector is
// counted eight bits a cycle, then the result beat is offered; the next
// item is taken only once that result beat has been accepted. Entry contents
// are not reset; only cells below the occupancy are ever looked at.
module sorted_list_insert_search_delete (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [slisd_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] value
  input  wire logic [slisd_pkg::OP_W-1:0]         in_tuser,   // [1:0] op
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [slisd_pkg::OUT_TDATA_W-1:0]       out_tdata,  // [4:0] match_count,
                                                              // [9:5] occupancy
  output logic [slisd_pkg::STATUS_W-1:0]          out_tuser   // [1:0] status
);

  localparam int N = slisd_pkg::CAPACITY;

  slisd_pkg::state_t                   state_r;
  slisd_pkg::state_t                   state_nxt;
  slisd_pkg::op_t                      op_r;
  logic signed [slisd_pkg::VAL_W-1:0]  key_r;
  logic [slisd_pkg::CNT_W-1:0]         count_r;
  logic [slisd_pkg::CNT_W-1:0]         count_nxt;
  slisd_pkg::status_t                  status_r;
  slisd_pkg::status_t                  status_nxt;
  logic [slisd_pkg::EQ_W-1:0]          eq_vec_r;
  logic [slisd_pkg::EQ_W-1:0]          eq_vec_nxt;
  logic [slisd_pkg::CNT_W-1:0]         match_r;
  logic [slisd_pkg::CNT_W-1:0]         match_nxt;
  logic [slisd_pkg::GRP_W-1:0]         grp_r;
  logic [slisd_pkg::GRP_W-1:0]         grp_nxt;
  logic [slisd_pkg::POP_W-1:0]         grp_pop;

  slisd_pkg::cell_cmd_t                cmd;
  logic signed [slisd_pkg::VAL_W-1:0]  cell_val [N];
  logic [N-1:0]                        occ;
  logic [N-1:0]                        lt;
  logic [N-1:0]                        eq;
  logic [N-1:0]                        hit;
  logic                                full;
  logic                                empty;
  logic                                in_beat;
  logic                                out_beat;
  logic                                count_last;

  assign in_beat    = in_tvalid && in_tready;
  assign out_beat   = out_tvalid && out_tready;
  assign full       = (count_r == slisd_pkg::CNT_W'(N));
  assign empty      = (count_r == '0);
  assign count_last = (grp_r == slisd_pkg::GRP_W'(slisd_pkg::NGRP - 1));

  // Broadcast command, live only in the execute cycle.
  always_comb begin
    cmd.key    = key_r;
    cmd.ins_en = (state_r == slisd_pkg::S_EXEC) && (op_r == slisd_pkg::OP_INSERT) && !full;
    cmd.del_en = (state_r == slisd_pkg::S_EXEC) && (op_r == slisd_pkg::OP_DELETE);
  end

  // Chain of cells; each sees its left and right neighbor.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                               l_lt;
    logic                               l_occ;
    logic                               h_in;
    logic signed [slisd_pkg::VAL_W-1:0] l_val;
    logic signed [slisd_pkg::VAL_W-1:0] r_val;

    assign occ[i] = (count_r > slisd_pkg::CNT_W'(i));

    if (i == 0) begin : g_first
      assign l_lt  = 1'b1;
      assign l_occ = 1'b0;
      assign h_in  = 1'b0;
      assign l_val = key_r;
    end else begin : g_inner
      assign l_lt  = lt[i-1];
      assign l_occ = occ[i-1];
      assign h_in  = hit[i-1];
      assign l_val = cell_val[i-1];
    end

    if (i == N - 1) begin : g_last
      assign r_val = cell_val[i];
    end else begin : g_mid
      assign r_val = cell_val[i+1];
    end

    slisd_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[i]),
      .left_lt   (l_lt),
      .left_occ  (l_occ),
      .left_val  (l_val),
      .right_val (r_val),
      .hit_in    (h_in),
      .val       (cell_val[i]),
      .lt        (lt[i]),
      .eq        (eq[i]),
      .hit_out   (hit[i])
    );
  end

  // Population count of the lowest group of the match vector.
  always_comb begin
    grp_pop = '0;
    for (int b = 0; b < slisd_pkg::GRP_BITS; b++) begin
      grp_pop = grp_pop + slisd_pkg::POP_W'(eq_vec_r[b]);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slisd_pkg::S_IDLE: begin
        if (in_beat) begin
          state_nxt = slisd_pkg::S_EXEC;
        end
      end
      slisd_pkg::S_EXEC: begin
        state_nxt = slisd_pkg::S_COUNT;
      end
      slisd_pkg::S_COUNT: begin
        if (count_last) begin
          state_nxt = slisd_pkg::S_DONE;
        end
      end
      slisd_pkg::S_DONE: begin
        if (out_beat) begin
          state_nxt = slisd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = slisd_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_tready  = (state_r == slisd_pkg::S_IDLE);
    out_tvalid = (state_r == slisd_pkg::S_DONE);
    out_tuser  = status_r;
    out_tdata  = {{slisd_pkg::OUT_PAD_W{1'b0}},
                  slisd_pkg::OUT_CNT_W'(count_r),
                  slisd_pkg::OUT_CNT_W'(match_r)};
  end

  // Occupancy, status, match vector and the counting sweep.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    eq_vec_nxt = eq_vec_r;
    match_nxt  = match_r;
    grp_nxt    = grp_r;
    case (state_r)
      slisd_pkg::S_EXEC: begin
        eq_vec_nxt = '0;
        match_nxt  = '0;
        grp_nxt    = '0;
        status_nxt = slisd_pkg::ST_OK;
        case (op_r)
          slisd_pkg::OP_INSERT: begin
            if (full) begin
              status_nxt = slisd_pkg::ST_FULL;
            end else begin
              count_nxt = count_r + slisd_pkg::CNT_W'(1);
            end
          end
          slisd_pkg::OP_SEARCH: begin
            if (empty) begin
              status_nxt = slisd_pkg::ST_EMPTY;
            end else if (!hit[N-1]) begin
              status_nxt = slisd_pkg::ST_NOT_FOUND;
            end else begin
              eq_vec_nxt = slisd_pkg::EQ_W'(eq);
            end
          end
          slisd_pkg::OP_DELETE: begin
            if (empty) begin
              status_nxt = slisd_pkg::ST_EMPTY;
            end else if (!hit[N-1]) begin
              status_nxt = slisd_pkg::ST_NOT_FOUND;
            end else begin
              count_nxt = count_r - slisd_pkg::CNT_W'(1);
            end
          end
          default: begin
            status_nxt = slisd_pkg::ST_OK;
          end
        endcase
      end
      slisd_pkg::S_COUNT: begin
        match_nxt  = match_r + slisd_pkg::CNT_W'(grp_pop);
        eq_vec_nxt = eq_vec_r >> slisd_pkg::GRP_BITS;
        grp_nxt    = grp_r + slisd_pkg::GRP_W'(1);
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slisd_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Item and result registers.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r  <= slisd_pkg::op_t'(in_tuser);
      key_r <= in_tdata;
    end
    status_r <= status_nxt;
    eq_vec_r <= eq_vec_nxt;
    match_r  <= match_nxt;
    grp_r    <= grp_nxt;
  end

  // The list never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= slisd_pkg::CNT_W'(N))
    else $error("occupancy above capacity");

  // One item at a time: no new beat while a result is offered.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // An insert into a list with room grows it by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slisd_pkg::S_EXEC && op_r == slisd_pkg::OP_INSERT && !full)
    |=> count_r == $past(count_r) + slisd_pkg::CNT_W'(1))
    else $error("insert did not grow the list");

  // A nonzero match count comes only with an ok status.
  a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && match_r != '0) |-> status_r == slisd_pkg::ST_OK)
    else $error("matches reported with a failing status");

endmodule

`default_nettype wire

[bench/tb_sorted_list_insert_search_delete.sv]
`default_nettype none

module tb_sorted_list_insert_search_delete;
  timeunit 1ns;
  timeprecision 1ps;

  // One result beat, split into its fields.
  typedef struct packed {
    slisd_pkg::status_t                st;
    logic [slisd_pkg::OUT_CNT_W-1:0]   hit_cnt;
    logic [slisd_pkg::OUT_CNT_W-1:0]   occ;
  } list_result_t;

  // One row of the directed part: an operation repeated reps times. Where typed
  // is set, the result is written out here instead of taken from the predictor.
  typedef struct packed {
    slisd_pkg::op_t                    op;
    logic [slisd_pkg::VAL_W-1:0]       value;
    logic [4:0]                        reps;
    logic                              typed;
    list_result_t                      res;
  } dir_row_t;

  localparam int N_DIR       = 16;
  localparam int N_RANDOM    = 420;
  localparam int HOLD_AT     = 150;
  localparam int CALM_FROM   = 360;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // Operations on the empty list, and the reserved operation.
    '{slisd_pkg::OP_SEARCH, 32'h0000_0000, 5'd1, 1'b1, '{slisd_pkg::ST_EMPTY, 5'd0, 5'd0}},
    '{slisd_pkg::OP_DELETE, 32'h0000_0005, 5'd1, 1'b1, '{slisd_pkg::ST_EMPTY, 5'd0, 5'd0}},
    '{slisd_pkg::OP_RSVD,   32'hFFFF_FFFF, 5'd1, 1'b1, '{slisd_pkg::ST_OK, 5'd0, 5'd0}},
    // Fill the list with equal values, then overflow it and count them all.
    '{slisd_pkg::OP_INSERT, 32'hFFFF_FFFF, 5'd16, 1'b0, '{slisd_pkg::ST_OK, 5'd0, 5'd0}},
    '{slisd_pkg::OP_INSERT, 32'h7FFF_FFFF, 5'd1, 1'b1, '{slisd_pkg::ST_FULL, 5'd0, 5'd16}},
    '{slisd_pkg::OP_SEARCH, 32'hFFFF_FFFF, 5'd1, 1'b1, '{slisd_pkg::ST_OK, 5'd16, 5'd16}},
    // Make room and place both extremes of the value range.
    '{slisd_pkg::OP_DELETE, 32'hFFFF_FFFF, 5'd2, 1'b0, '{slisd_pkg::ST_OK, 5'd0, 5'd0}},
    '{slisd_pkg::OP_INSERT, 32'h7FFF_FFFF, 5'd1, 1'b1, '{slisd_pkg::ST_OK, 5'd0, 5'd15}},
    '{slisd_pkg::OP_INSERT, 32'h8000_0000, 5'd1, 1'b1, '{slisd_pkg::ST_OK, 5'd0, 5'd16}},
    '{slisd_pkg::OP_SEARCH, 32'h8000_0000, 5'd1, 1'b1, '{slisd_pkg::ST_OK, 5'd1, 5'd16}},
    '{slisd_pkg::OP_SEARCH, 32'h0000_0005, 5'd1, 1'b1,
      '{slisd_pkg::ST_NOT_FOUND, 5'd0, 5'd16}},
    '{slisd_pkg::OP_DELETE, 32'h0000_0005, 5'd1, 1'b1,
      '{slisd_pkg::ST_NOT_FOUND, 5'd0, 5'd16}},
    '{slisd_pkg::OP_DELETE, 32'h7FFF_FFFF, 5'd1, 1'b1, '{slisd_pkg::ST_OK, 5'd0, 5'd15}},
    '{slisd_pkg::OP_DELETE, 32'h8000_0000, 5'd1, 1'b1, '{slisd_pkg::ST_OK, 5'd0, 5'd14}},
    // Alternating bit patterns.
    '{slisd_pkg::OP_INSERT, 32'h5555_5555, 5'd1, 1'b0, '{slisd_pkg::ST_OK, 5'd0, 5'd0}},
    '{slisd_pkg::OP_INSERT, 32'hAAAA_AAAA, 5'd1, 1'b0, '{slisd_pkg::ST_OK, 5'd0, 5'd0}}
  };

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [slisd_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [slisd_pkg::OP_W-1:0]        in_tuser   = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [slisd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [slisd_pkg::STATUS_W-1:0]    out_tuser;

  // Shadow copy of the list and the results still owed by the block.
  logic signed [slisd_pkg::VAL_W-1:0] list_cells [slisd_pkg::CAPACITY];
  int                                 list_len = 0;
  list_result_t                       pending_results [$];
  int                                 errors = 0;

  // Controls shared between the sender and the receiver, and the receiver's own counters.
  logic calm      = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   stall_left = 0;
  int   hold_left  = 0;

  sorted_list_insert_search_delete uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the shadow list and return the result it gives.
  function automatic list_result_t apply_list_op(slisd_pkg::op_t op,
                                                 logic [slisd_pkg::VAL_W-1:0] value);
    logic signed [slisd_pkg::VAL_W-1:0] key;
    int                                 pos;
    int                                 hits;
    list_result_t                       res;
    key         = value;
    pos         = 0;
    hits        = 0;
    res.st      = slisd_pkg::ST_OK;
    res.hit_cnt = '0;
    case (op)
      slisd_pkg::OP_INSERT: begin
        if (list_len >= slisd_pkg::CAPACITY) begin
          res.st = slisd_pkg::ST_FULL;
        end else begin
          while (pos < list_len && list_cells[pos] < key) pos++;
          for (int i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
          list_cells[pos] = key;
          list_len++;
        end
      end
      slisd_pkg::OP_SEARCH: begin
        if (list_len == 0) begin
          res.st = slisd_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < list_len; i++) if (list_cells[i] == key) hits++;
          res.st      = (hits != 0) ? slisd_pkg::ST_OK : slisd_pkg::ST_NOT_FOUND;
          res.hit_cnt = slisd_pkg::OUT_CNT_W'(hits);
        end
      end
      slisd_pkg::OP_DELETE: begin
        if (list_len == 0) begin
          res.st = slisd_pkg::ST_EMPTY;
        end else begin
          while (pos < list_len && list_cells[pos] != key) pos++;
          if (pos >= list_len) begin
            res.st = slisd_pkg::ST_NOT_FOUND;
          end else begin
            for (int i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
            list_len--;
          end
        end
      end
      default: ;
    endcase
    res.occ = slisd_pkg::OUT_CNT_W'(list_len);
    return res;
  endfunction

  // Keys are mostly stored entries or small numbers, so that searches and
  // deletes hit often; the rest are extremes and full-width random words.
  function automatic logic [slisd_pkg::VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && list_len > 0) return list_cells[$urandom_range(0, list_len - 1)];
    if (sel < 7) begin
      return slisd_pkg::VAL_W'($urandom_range(0, 8)) - slisd_pkg::VAL_W'(4);
    end
    if (sel == 7) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom();
  endfunction

  // Offer one beat, maybe after a gap, and record its result on acceptance.
  task automatic send_item(input slisd_pkg::op_t op,
                           input logic [slisd_pkg::VAL_W-1:0] value,
                           input logic typed, input list_result_t typed_res);
    list_result_t res;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    res = apply_list_op(op, value);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // Sender: reset, the directed rows, then random traffic that swings between
  // filling the list to capacity and draining it to empty.
  initial begin
    slisd_pkg::op_t              op;
    logic [slisd_pkg::VAL_W-1:0] value;
    int                          r;
    logic                        filling;
    filling = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int d = 0; d < N_DIR; d++) begin
      for (int k = 0; k < DIR_ROWS[d].reps; k++) begin
        send_item(DIR_ROWS[d].op, DIR_ROWS[d].value, DIR_ROWS[d].typed, DIR_ROWS[d].res);
      end
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == HOLD_AT) hold_req <= 1'b1;
      if (i == CALM_FROM) calm <= 1'b1;
      r = $urandom_range(0, 99);
      if (filling) begin
        op = (r < 60) ? slisd_pkg::OP_INSERT :
             (r < 80) ? slisd_pkg::OP_SEARCH :
             (r < 95) ? slisd_pkg::OP_DELETE : slisd_pkg::OP_RSVD;
      end else begin
        op = (r < 15) ? slisd_pkg::OP_INSERT :
             (r < 35) ? slisd_pkg::OP_SEARCH :
             (r < 95) ? slisd_pkg::OP_DELETE : slisd_pkg::OP_RSVD;
      end
      value = pick_value();
      send_item(op, value, 1'b0, '0);
      // Turn around only after lingering a while at full or at empty.
      if (list_len == slisd_pkg::CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (list_len == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
    end
    in_tvalid <= 1'b0;

    // Let the last results drain, then allow for stray beats.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off so that the block backs
  // up into its input, and a steady ready once the run calms down.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare every result beat with the oldest outstanding result.
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing outstanding: status %0d tdata %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser != want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, out_tuser);
          errors++;
        end
        if (out_tdata[slisd_pkg::OUT_CNT_W-1:0] != want.hit_cnt) begin
          $display("%0t: match_count expected %0d actual %0d",
                   $time, want.hit_cnt, out_tdata[slisd_pkg::OUT_CNT_W-1:0]);
          errors++;
        end
        if (out_tdata[2*slisd_pkg::OUT_CNT_W-1:slisd_pkg::OUT_CNT_W] != want.occ) begin
          $display("%0t: occupancy expected %0d actual %0d",
                   $time, want.occ,
                   out_tdata[2*slisd_pkg::OUT_CNT_W-1:slisd_pkg::OUT_CNT_W]);
          errors++;
        end
        if (out_tdata[slisd_pkg::OUT_TDATA_W-1:2*slisd_pkg::OUT_CNT_W] != '0) begin
          $display("%0t: tdata padding expected 0 actual %h",
                   $time, out_tdata[slisd_pkg::OUT_TDATA_W-1:2*slisd_pkg::OUT_CNT_W]);
          errors++;
        end
      end
    end
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
